@@ rtl/ppgbd_pkg.sv @@
// Package for the PPG beat detector: widths, constants and shared types.
`default_nettype none
package ppgbd_pkg;
	localparam int SAMPLE_W = 20;
	localparam int AMP_W = 19;
	localparam int REG_W = 10;
	localparam int CFG_DATA_W = 19;
	localparam int CFG_IDX_W = 3;
	localparam int THR_W = 36;
	localparam int SINCE_W = 11;
	localparam int IVL_W = 10;
	localparam int SLOPE_SPAN_DEF = 4;
	localparam int MEDIAN_DEPTH_DEF = 8;
	localparam logic [16:0] DECAY_Q16 = 17'd65405;
	localparam logic [16:0] KEEP_Q16 = 17'd60293;
	localparam logic [16:0] GAIN_Q16 = 17'd5243;

	localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_RATE = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_REFRACTORY = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_INTERVAL = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_INTERVAL = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_WARMUP = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_AMP = 3'd6;

	// Request passed from the front part to the back part.
	typedef struct packed {
		logic warm;
		logic crossing;
		logic [AMP_W-1:0] amp;
		logic [SINCE_W-1:0] since;
	} front_req_t;

	typedef struct packed {
		logic [REG_W-1:0] sample_rate_hz;
		logic [REG_W-1:0] refractory_len;
		logic [REG_W-1:0] min_interval;
		logic [REG_W-1:0] max_interval;
		logic [REG_W-1:0] warmup_len;
		logic [REG_W-1:0] timeout_len;
		logic [AMP_W-1:0] min_amplitude;
	} cfg_t;
endpackage
`default_nettype wire

@@ rtl/ppg_beat_detector.sv @@
// Top level of the PPG beat detector.
`default_nettype none
// PPG beat detector: one 20-bit sample in, one result out per sample. A front
// stage computes the slope and marks peak candidates; a sequencer in the back
// runs the threshold, gates, median rank search and a 16-step divider. A
// warm-up sample gives its result in the cycle after it is taken; other samples
// pass through decay and gating, and an accepted beat with a stored interval
// also runs the median search and then the divide before its result. A
// new request is taken only once the previous result has been popped.
module ppg_beat_detector #(
	parameter int SLOPE_SPAN = ppgbd_pkg::SLOPE_SPAN_DEF,
	parameter int MEDIAN_DEPTH = ppgbd_pkg::MEDIAN_DEPTH_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	output logic full,
	input  wire logic signed [ppgbd_pkg::SAMPLE_W-1:0] sample,
	output logic empty,
	input  wire logic pop,
	output logic [7:0] beats_per_minute,
	output logic beat_found,
	output logic [ppgbd_pkg::AMP_W-1:0] beat_height,
	input  wire logic cfg_we,
	input  wire logic [ppgbd_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [ppgbd_pkg::CFG_DATA_W-1:0] cfg_data
);
	import ppgbd_pkg::*;
	cfg_t cfg_q;
	logic in_ready, req_valid, req_ready, beat_accept;
	front_req_t req;

	assign full = !in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.sample_rate_hz <= 10'd100;
			cfg_q.refractory_len <= 10'd40;
			cfg_q.min_interval <= 10'd40;
			cfg_q.max_interval <= 10'd200;
			cfg_q.warmup_len <= 10'd500;
			cfg_q.timeout_len <= 10'd300;
			cfg_q.min_amplitude <= 19'd100;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SAMPLE_RATE: cfg_q.sample_rate_hz <= cfg_data[REG_W-1:0];
				REG_REFRACTORY: cfg_q.refractory_len <= cfg_data[REG_W-1:0];
				REG_MIN_INTERVAL: cfg_q.min_interval <= cfg_data[REG_W-1:0];
				REG_MAX_INTERVAL: cfg_q.max_interval <= cfg_data[REG_W-1:0];
				REG_WARMUP: cfg_q.warmup_len <= cfg_data[REG_W-1:0];
				REG_TIMEOUT: cfg_q.timeout_len <= cfg_data[REG_W-1:0];
				REG_MIN_AMP: cfg_q.min_amplitude <= cfg_data[AMP_W-1:0];
				default: ;
			endcase
		end
	end

	ppgbd_front #(.SLOPE_SPAN(SLOPE_SPAN)) u_front (
		.clk, .arst_n, .in_valid(push), .in_ready, .sample, .cfg(cfg_q),
		.req_valid, .req_ready, .req, .beat_accept
	);

	ppgbd_back #(.MEDIAN_DEPTH(MEDIAN_DEPTH)) u_back (
		.clk, .arst_n, .cfg(cfg_q), .req_valid, .req_ready, .req, .beat_accept,
		.empty, .pop, .beats_per_minute, .beat_found, .beat_height
	);
endmodule
`default_nettype wire

@@ rtl/ppgbd_front.sv @@
// Front part: slope, rise tracking, warm-up and crossing classification.
`default_nettype none
module ppgbd_front #(
	parameter int SLOPE_SPAN = ppgbd_pkg::SLOPE_SPAN_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic in_ready,
	input  wire logic signed [ppgbd_pkg::SAMPLE_W-1:0] sample,
	input  wire ppgbd_pkg::cfg_t cfg,
	output logic req_valid,
	input  wire logic req_ready,
	output ppgbd_pkg::front_req_t req,
	input  wire logic beat_accept
);
	import ppgbd_pkg::*;
	localparam int PW = (SLOPE_SPAN > 1) ? $clog2(SLOPE_SPAN) : 1;

	logic signed [SAMPLE_W-1:0] line_q [SLOPE_SPAN];
	logic [PW-1:0] ptr_q;
	logic pos_q;
	logic signed [SAMPLE_W-1:0] rise_q;
	logic [REG_W-1:0] warm_q;
	logic [SINCE_W-1:0] since_q;
	logic signed [SAMPLE_W:0] d;
	logic [REG_W-1:0] warm_n;
	logic signed [SAMPLE_W-1:0] rise_n;
	logic [SINCE_W-1:0] since_n;
	logic in_warm, fire;

	// The back part resets since_q when it accepts a beat; the front only
	// counts, so the back hands its reset back as a one-cycle strobe on
	// beat_accept while no new request can be taken.
	assign in_ready = req_ready;
	assign fire = in_valid && in_ready;
	assign d = {sample[SAMPLE_W-1], sample} - {line_q[ptr_q][SAMPLE_W-1], line_q[ptr_q]};
	assign warm_n = (warm_q != '1) ? warm_q + 1'b1 : warm_q;
	assign rise_n = (d > 0 && sample > rise_q) ? sample : rise_q;
	assign since_n = (since_q != '1) ? since_q + 1'b1 : since_q;
	assign in_warm = warm_n < cfg.warmup_len;

	always_comb begin
		req_valid = fire;
		req.warm = in_warm;
		req.crossing = pos_q && !(d > 0);
		req.amp = rise_n[SAMPLE_W-1] ? '0 : rise_n[AMP_W-1:0];
		req.since = since_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SLOPE_SPAN; i++) line_q[i] <= '0;
			ptr_q <= '0;
			pos_q <= 1'b0;
			rise_q <= '0;
			warm_q <= '0;
			since_q <= SINCE_W'(41);
		end else begin
			if (fire) begin
				line_q[ptr_q] <= sample;
				ptr_q <= (ptr_q == PW'(SLOPE_SPAN - 1)) ? '0 : ptr_q + 1'b1;
				warm_q <= warm_n;
				pos_q <= d > 0;
				rise_q <= (in_warm || req.crossing) ? '0 : rise_n;
			end
			if (beat_accept)
				since_q <= '0;
			else if (fire)
				since_q <= since_n;
		end
	end
endmodule
`default_nettype wire

@@ rtl/ppgbd_back.sv @@
// Back part: threshold, gating, median store, rate division and result queue.
`default_nettype none
module ppgbd_back #(
	parameter int MEDIAN_DEPTH = ppgbd_pkg::MEDIAN_DEPTH_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire ppgbd_pkg::cfg_t cfg,
	input  wire logic req_valid,
	output logic req_ready,
	input  wire ppgbd_pkg::front_req_t req,
	output logic beat_accept,
	output logic empty,
	input  wire logic pop,
	output logic [7:0] beats_per_minute,
	output logic beat_found,
	output logic [ppgbd_pkg::AMP_W-1:0] beat_height
);
	import ppgbd_pkg::*;
	localparam int MW = (MEDIAN_DEPTH > 1) ? $clog2(MEDIAN_DEPTH) : 1;
	localparam int FW = $clog2(MEDIAN_DEPTH + 1);
	localparam int CW = $clog2(MEDIAN_DEPTH + 1);
	localparam int NUM_W = 16;

	typedef enum logic [5:0] {
		ST_IDLE = 6'b000001,
		ST_DECAY = 6'b000010,
		ST_GATE = 6'b000100,
		ST_UPD = 6'b001000,
		ST_MED = 6'b010000,
		ST_DIV = 6'b100000
	} state_t;

	state_t state_q;
	front_req_t r_q;
	logic [THR_W-1:0] thr_q;
	logic [7:0] rate_q;
	logic [IVL_W-1:0] store_q [MEDIAN_DEPTH];
	logic [MW-1:0] sptr_q;
	logic [FW-1:0] fill_q;
	logic [MW-1:0] cand_q;
	logic [IVL_W-1:0] med_q;
	logic [NUM_W-1:0] rem_q;
	logic [8:0] quo_q;
	logic [4:0] dstep_q;
	logic found_q;
	logic out_full_q;
	logic [7:0] out_bpm_q;
	logic out_found_q;
	logic [AMP_W-1:0] out_amp_q;

	logic [THR_W-1:0] floor_q36;
	logic [THR_W-1:0] amp_q36;
	logic [THR_W+16:0] prod_decay;
	logic [THR_W+1:0] thr2;
	logic [THR_W-1:0] capped;
	logic [THR_W+17:0] upd_sum;
	logic [THR_W+4:0] lhs, rhs;
	logic [CW-1:0] lt_cnt, le_cnt;
	logic [IVL_W-1:0] cval;
	logic [FW-1:0] half;
	logic [NUM_W-1:0] numer;
	logic [3:0] nbit;
	logic [NUM_W:0] trial;

	assign floor_q36 = {1'b0, cfg.min_amplitude, 16'd0};
	assign amp_q36 = {1'b0, r_q.amp, 16'd0};
	assign prod_decay = thr_q * DECAY_Q16;
	assign thr2 = {thr_q, 1'b0};
	assign capped = ({2'b00, amp_q36} > thr2) ? thr2[THR_W-1:0] : amp_q36;
	assign upd_sum = thr_q * KEEP_Q16 + capped * GAIN_Q16;
	assign lhs = {amp_q36, 3'd0} + {2'b00, amp_q36, 1'b0};
	assign rhs = {3'd0, thr_q, 1'b0} + {5'd0, thr_q};
	assign half = fill_q >> 1;
	assign cval = store_q[cand_q];
	assign numer = {6'd0, cfg.sample_rate_hz} * 16'd60;
	// Divide steps 1 to 16 bring in numerator bits 15 down to 0.
	assign nbit = 4'd0 - dstep_q[3:0];
	assign trial = {rem_q, numer[nbit]} - {7'd0, med_q};

	// Rank count of one candidate per cycle: it is the median when the number
	// of smaller entries is at most half and the number not larger exceeds it.
	always_comb begin
		lt_cnt = '0;
		le_cnt = '0;
		for (int i = 0; i < MEDIAN_DEPTH; i++) begin
			if (FW'(i) < fill_q) begin
				if (store_q[i] < cval) lt_cnt = lt_cnt + 1'b1;
				if (store_q[i] <= cval) le_cnt = le_cnt + 1'b1;
			end
		end
	end

	assign req_ready = (state_q == ST_IDLE) && !out_full_q;
	assign empty = !out_full_q;
	assign beats_per_minute = out_bpm_q;
	assign beat_found = out_found_q;
	assign beat_height = out_amp_q;

	always_ff @(posedge clk) begin
		if (state_q == ST_UPD && r_q.since >= SINCE_W'(cfg.min_interval)
				&& r_q.since <= SINCE_W'(cfg.max_interval))
			store_q[sptr_q] <= r_q.since[IVL_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			r_q <= '0;
			thr_q <= '0;
			rate_q <= '0;
			sptr_q <= '0;
			fill_q <= '0;
			cand_q <= '0;
			med_q <= '0;
			rem_q <= '0;
			quo_q <= '0;
			dstep_q <= '0;
			found_q <= 1'b0;
			out_full_q <= 1'b0;
			out_bpm_q <= '0;
			out_found_q <= 1'b0;
			out_amp_q <= '0;
			beat_accept <= 1'b0;
		end else begin
			beat_accept <= 1'b0;
			if (pop && out_full_q) out_full_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (req_valid && req_ready) begin
						r_q <= req;
						found_q <= 1'b0;
						if (req.warm) begin
							out_full_q <= 1'b1;
							out_bpm_q <= '0;
							out_found_q <= 1'b0;
							out_amp_q <= '0;
						end else begin
							if (rate_q != 0 && req.since > SINCE_W'(cfg.timeout_len)) begin
								rate_q <= '0;
								fill_q <= '0;
								thr_q <= '0;
							end
							state_q <= ST_DECAY;
						end
					end
				end
				ST_DECAY: begin
					if (thr_q > floor_q36) thr_q <= prod_decay[THR_W+15:16];
					state_q <= (r_q.crossing && r_q.amp >= cfg.min_amplitude)
						? ST_GATE : ST_DIV;
					dstep_q <= '0;
				end
				ST_GATE: begin
					// A level below the floor is seeded with this peak first.
					if (thr_q < floor_q36)
						thr_q <= amp_q36;
					else if (lhs < rhs || r_q.since <= SINCE_W'(cfg.refractory_len))
						state_q <= ST_DIV;
					else begin
						found_q <= 1'b1;
						beat_accept <= 1'b1;
						state_q <= ST_UPD;
					end
				end
				ST_UPD: begin
					thr_q <= upd_sum[THR_W+15:16];
					if (r_q.since >= SINCE_W'(cfg.min_interval)
							&& r_q.since <= SINCE_W'(cfg.max_interval)) begin
						sptr_q <= (sptr_q == MW'(MEDIAN_DEPTH - 1)) ? '0 : sptr_q + 1'b1;
						if (fill_q < FW'(MEDIAN_DEPTH)) fill_q <= fill_q + 1'b1;
						cand_q <= '0;
						state_q <= ST_MED;
					end else
						state_q <= ST_DIV;
					dstep_q <= '0;
				end
				ST_MED: begin
					if (CW'(lt_cnt) <= CW'(half) && CW'(le_cnt) > CW'(half)) begin
						med_q <= cval;
						rem_q <= '0;
						quo_q <= '0;
						dstep_q <= 5'd1;
						state_q <= ST_DIV;
					end else
						cand_q <= cand_q + 1'b1;
				end
				ST_DIV: begin
					// Restoring division of sample rate*60 by the median, one bit a cycle.
					if (dstep_q == '0 || med_q == '0) begin
						out_full_q <= 1'b1;
						out_bpm_q <= rate_q;
						out_found_q <= found_q;
						out_amp_q <= found_q ? r_q.amp : '0;
						state_q <= ST_IDLE;
					end else if (dstep_q == 5'd17) begin
						rate_q <= (quo_q > 9'd255) ? 8'd255 : quo_q[7:0];
						out_full_q <= 1'b1;
						out_bpm_q <= (quo_q > 9'd255) ? 8'd255 : quo_q[7:0];
						out_found_q <= 1'b1;
						out_amp_q <= r_q.amp;
						state_q <= ST_IDLE;
					end else begin
						if (!trial[NUM_W])
							rem_q <= trial[NUM_W-1:0];
						else
							rem_q <= {rem_q[NUM_W-2:0], numer[nbit]};
						// Once the quotient passes 255 it only has to stay there.
						quo_q <= quo_q[8] ? quo_q : {quo_q[7:0], !trial[NUM_W]};
						dstep_q <= dstep_q + 1'b1;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire
